>>> sv/kmsr_pkg.sv
// Shared types and constants for the one-dimensional k-means refinement block.
`default_nettype none
package kmsr_pkg;
  localparam int ValW  = 32;
  localparam int DistW = ValW + 1;
  localparam int IdxW  = 6;
  localparam logic [31:0] ThirdRecip = 32'hAAAA_AAAB;

  typedef struct packed {
    logic                    vld;
    logic signed [ValW-1:0]  val;
    logic [DistW-1:0]        gap;
    logic [IdxW-1:0]         idx;
  } kmsr_pt_t;
endpackage
`default_nettype wire

>>> sv/kmeans_1d_split_refine_top.sv
// Top level of the one-dimensional k-means refinement block.
// Centroid and point words load at one word per cycle while idle. A point word with last set
// starts the run: each of iteration_count passes streams the P stored points, one per
// cycle, through a row of MAX_CENTROIDS centroid cells, then updates each non-empty
// cluster with a bit-serial divider on SUM_W-bit sums (SUM_W = 32 + clog2(MAX_POINTS+1))
// and may split the widest cluster. The final odd-even sort orders the centroids, and
// results leave one per cycle unless out_ready_i holds them.
`default_nettype none
module kmeans_1d_split_refine_top #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_POINTS    = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      centroid_o,
  output logic [3:0]              slot_o,
  output logic                    final_res_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [3:0]         cfg_data_i
);
  import kmsr_pkg::*;

  localparam int CW   = $clog2(MAX_CENTROIDS + 1);
  localparam int IW   = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int PW   = $clog2(MAX_POINTS + 1);
  localparam int PA   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUMW = ValW + PW;
  localparam int DVW  = (PW > 2) ? PW : 2;
  localparam int DRW  = $clog2(MAX_CENTROIDS + 4);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_FEED = 4'd2;
  localparam logic [3:0] S_DRN  = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_DIVW = 4'd5;
  localparam logic [3:0] S_SPLD = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_SORT = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  st_q, st_d;
  logic [3:0]  iter_q;
  logic [CW-1:0] ctot_q, ctot_d, act_q, act_d, j_q, j_d, ic_q, ic_d, wid_q, wid_d;
  logic [CW-1:0] rnd_q, rnd_d, o_q, o_d;
  logic [PW-1:0] ptot_q, ptot_d, fi_q, fi_d;
  logic [3:0]  pass_q, pass_d;
  logic [DRW-1:0] drn_q, drn_d;
  logic [DistW-1:0] maxd_q, maxd_d;
  logic signed [31:0] lb_q, lb_d, ub_q, ub_d;
  logic [31:0] span_q, span_d;
  logic        neg_q, neg_d;

  logic signed [31:0] pmem [MAX_POINTS];
  logic signed [31:0] rd_q;
  logic        fv_q, fv_d;

  logic signed [SUMW-1:0] sum_q [MAX_CENTROIDS];
  logic [PW-1:0]          cnt_q [MAX_CENTROIDS];
  logic signed [31:0]     min_q [MAX_CENTROIDS];
  logic signed [31:0]     max_q [MAX_CENTROIDS];

  kmsr_pt_t           chain [MAX_CENTROIDS+1];
  logic signed [31:0] cent [MAX_CENTROIDS];
  logic               cw_en [MAX_CENTROIDS];
  logic signed [31:0] cw_dat [MAX_CENTROIDS];
  logic               swp [MAX_CENTROIDS];

  logic               div_start, div_busy, div_done;
  logic [SUMW-1:0]    div_a, div_quot;
  logic [DVW-1:0]     div_b;
  logic signed [31:0] mean, third;
  logic [63:0]        third_prod;
  logic [DistW-1:0]   diam;
  logic [IW-1:0]      jx;

  logic               ov_q;
  logic signed [31:0] oc_q;
  logic [3:0]         os_q;
  logic               of_q;
  logic               in_acc, out_load;

  assign in_ready_o  = (st_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign jx          = j_q[IW-1:0];
  assign third_prod  = {32'd0, span_q} * {32'd0, ThirdRecip};
  assign third       = {1'b0, third_prod[63:33]};
  assign mean        = neg_q ? -div_quot[31:0] : div_quot[31:0];
  assign diam        = DistW'($signed({max_q[jx][31], max_q[jx]})
                       - $signed({min_q[jx][31], min_q[jx]}));
  assign out_load    = (st_q == S_OUT) && (ctot_q != '0) && (!ov_q || out_ready_i);

  assign chain[0] = '{vld: fv_q, val: rd_q, gap: '1, idx: '0};

  for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
    kmsr_cell #(.CELL_IDX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (CW'(g) < act_q),
      .wr_en_i   (cw_en[g]),
      .wr_data_i (cw_dat[g]),
      .pt_i      (chain[g]),
      .pt_o      (chain[g+1]),
      .cent_o    (cent[g])
    );
  end

  kmsr_div #(.N(SUMW), .M(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    for (int j = 0; j < MAX_CENTROIDS; j++) begin
      swp[j] = (j + 1 < MAX_CENTROIDS) && (j[0] == rnd_q[0]) && (CW'(j + 1) < act_q)
               && (cent[j] > cent[(j + 1) % MAX_CENTROIDS]);
    end
    for (int j = 0; j < MAX_CENTROIDS; j++) begin
      cw_en[j]  = 1'b0;
      cw_dat[j] = cent[j];
      case (st_q)
        S_IDLE: begin
          if (in_acc && !opcode_i && ctot_q == CW'(j)) begin
            cw_en[j]  = 1'b1;
            cw_dat[j] = value_i;
          end
        end
        S_DIVW: begin
          if (div_done && ic_q == CW'(j)) begin
            cw_en[j]  = 1'b1;
            cw_dat[j] = mean;
          end
        end
        S_SPLD: begin
          if (wid_q == CW'(j)) begin
            cw_en[j]  = 1'b1;
            cw_dat[j] = lb_q + third;
          end else if (ic_q == CW'(j)) begin
            cw_en[j]  = 1'b1;
            cw_dat[j] = ub_q - third;
          end
        end
        S_SORT: begin
          if (swp[j]) begin
            cw_en[j]  = 1'b1;
            cw_dat[j] = cent[(j + 1) % MAX_CENTROIDS];
          end else if (j > 0 && swp[(j + MAX_CENTROIDS - 1) % MAX_CENTROIDS]) begin
            cw_en[j]  = 1'b1;
            cw_dat[j] = cent[(j + MAX_CENTROIDS - 1) % MAX_CENTROIDS];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st_d = st_q; ctot_d = ctot_q; ptot_d = ptot_q; act_d = act_q; j_d = j_q;
    ic_d = ic_q; wid_d = wid_q; rnd_d = rnd_q; o_d = o_q; fi_d = fi_q;
    pass_d = pass_q; drn_d = drn_q; maxd_d = maxd_q; lb_d = lb_q; ub_d = ub_q;
    span_d = span_q; neg_d = neg_q; fv_d = 1'b0;
    div_start = 1'b0; div_a = '0; div_b = '0;
    case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!opcode_i) begin
            if (ctot_q < CW'(MAX_CENTROIDS)) ctot_d = ctot_q + 1'b1;
          end else begin
            if (ptot_q < PW'(MAX_POINTS)) ptot_d = ptot_q + 1'b1;
            if (last_i) begin
              act_d  = ctot_q;
              pass_d = '0;
              rnd_d  = '0;
              st_d   = (iter_q == '0) ? S_SORT : S_CLR;
            end
          end
        end
      end
      S_CLR: begin
        fi_d = '0; j_d = '0; ic_d = '0; wid_d = '0; maxd_d = '0;
        lb_d = '0; ub_d = '0;
        st_d = S_FEED;
      end
      S_FEED: begin
        if (fi_q < ptot_q) begin
          fv_d = 1'b1;
          fi_d = fi_q + 1'b1;
        end else begin
          drn_d = '0;
          st_d  = S_DRN;
        end
      end
      S_DRN: begin
        drn_d = drn_q + 1'b1;
        if (drn_q == DRW'(MAX_CENTROIDS + 2)) st_d = S_UPD;
      end
      S_UPD: begin
        if (j_q >= act_q) begin
          if (ic_q != '0 && ic_q < ctot_q) begin
            span_d = ub_q - lb_q;
            st_d   = S_SPLD;
          end else begin
            act_d = ic_q;
            st_d  = S_NEXT;
          end
        end else if (cnt_q[jx] == '0) begin
          j_d = j_q + 1'b1;
        end else begin
          neg_d     = sum_q[jx][SUMW-1];
          div_start = 1'b1;
          div_a     = sum_q[jx][SUMW-1] ? SUMW'(-sum_q[jx]) : SUMW'(sum_q[jx]);
          div_b     = DVW'(cnt_q[jx]);
          st_d      = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          if (diam > maxd_q || ic_q == '0) begin
            if (diam > maxd_q) maxd_d = diam;
            wid_d = ic_q;
            lb_d  = min_q[jx];
            ub_d  = max_q[jx];
          end
          ic_d = ic_q + 1'b1;
          j_d  = j_q + 1'b1;
          st_d = S_UPD;
        end
      end
      S_SPLD: begin
        act_d = ic_q + 1'b1;
        st_d  = S_NEXT;
      end
      S_NEXT: begin
        pass_d = pass_q + 1'b1;
        if (pass_q + 1'b1 < iter_q) begin
          st_d = S_CLR;
        end else begin
          rnd_d = '0;
          st_d  = S_SORT;
        end
      end
      S_SORT: begin
        rnd_d = rnd_q + 1'b1;
        if (rnd_q >= CW'(MAX_CENTROIDS - 1)) begin
          o_d  = '0;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (ctot_q == '0) begin
          ptot_d = '0;
          st_d   = S_IDLE;
        end else if (out_load) begin
          o_d = o_q + 1'b1;
          if (o_q == ctot_q - 1'b1) begin
            ctot_d = '0;
            ptot_d = '0;
            st_d   = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; iter_q <= 4'd5; ctot_q <= '0; ptot_q <= '0; act_q <= '0;
      j_q <= '0; ic_q <= '0; wid_q <= '0; rnd_q <= '0; o_q <= '0; fi_q <= '0;
      pass_q <= '0; drn_q <= '0; maxd_q <= '0; lb_q <= '0; ub_q <= '0;
      span_q <= '0; neg_q <= 1'b0; fv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ctot_q <= ctot_d; ptot_q <= ptot_d; act_q <= act_d;
      j_q <= j_d; ic_q <= ic_d; wid_q <= wid_d; rnd_q <= rnd_d; o_q <= o_d;
      fi_q <= fi_d; pass_q <= pass_d; drn_q <= drn_d; maxd_q <= maxd_d;
      lb_q <= lb_d; ub_q <= ub_d; span_q <= span_d; neg_q <= neg_d; fv_q <= fv_d;
      if (cfg_valid_i) iter_q <= cfg_data_i;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && opcode_i && ptot_q < PW'(MAX_POINTS)) begin
      pmem[ptot_q[PA-1:0]] <= value_i;
    end
    rd_q <= pmem[fi_q[PA-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oc_q <= cent[o_q[IW-1:0]];
      os_q <= 4'(o_q);
      of_q <= (o_q == ctot_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_CENTROIDS; j++) begin
        sum_q[j] <= '0; cnt_q[j] <= '0; min_q[j] <= '0; max_q[j] <= '0;
      end
    end else if (st_q == S_CLR) begin
      for (int j = 0; j < MAX_CENTROIDS; j++) begin
        sum_q[j] <= '0; cnt_q[j] <= '0; min_q[j] <= '0; max_q[j] <= '0;
      end
    end else if (chain[MAX_CENTROIDS].vld) begin
      automatic logic [IW-1:0] k = chain[MAX_CENTROIDS].idx[IW-1:0];
      automatic logic signed [31:0] p = chain[MAX_CENTROIDS].val;
      if (cnt_q[k] == '0 || p < min_q[k]) min_q[k] <= p;
      if (cnt_q[k] == '0 || p > max_q[k]) max_q[k] <= p;
      sum_q[k] <= sum_q[k] + SUMW'(p);
      cnt_q[k] <= cnt_q[k] + 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign centroid_o  = oc_q;
  assign slot_o      = os_q;
  assign final_res_o = of_q;

  a_act_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> (act_q <= ctot_q))
    else $error("active cluster count exceeds loaded centroids");
  a_div_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (st_q == S_DIVW || st_q == S_SPLD))
    else $error("divider busy outside update");
  a_stats_in_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[MAX_CENTROIDS].vld |-> (st_q == S_FEED || st_q == S_DRN))
    else $error("point word left the cell row outside a pass");
endmodule
`default_nettype wire

>>> sv/kmsr_cell.sv
// Centroid cell: holds one centroid and passes the nearest-so-far point word on.
`default_nettype none
module kmsr_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       wr_en_i,
  input  wire logic signed [31:0]         wr_data_i,
  input  wire kmsr_pkg::kmsr_pt_t         pt_i,
  output kmsr_pkg::kmsr_pt_t              pt_o,
  output logic signed [31:0]              cent_o
);
  import kmsr_pkg::*;

  logic signed [ValW-1:0] cent_q;
  kmsr_pt_t               pt_d, pt_q;
  logic signed [DistW-1:0] diff;
  logic [DistW-1:0]       gap;

  always_comb begin
    diff = $signed({pt_i.val[ValW-1], pt_i.val}) - $signed({cent_q[ValW-1], cent_q});
    gap  = diff[DistW-1] ? DistW'(-diff) : DistW'(diff);
    pt_d = pt_i;
    if (en_i && pt_i.vld && (gap < pt_i.gap)) begin
      pt_d.gap = gap;
      pt_d.idx = IdxW'(CELL_IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
    end else begin
      pt_q <= pt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cent_q <= wr_data_i;
    end
  end

  assign pt_o   = pt_q;
  assign cent_o = cent_q;
endmodule
`default_nettype wire

>>> sv/kmsr_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module kmsr_div #(
  parameter int N = 41,
  parameter int M = 9
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] dividend_i,
  input  wire logic [M-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [N-1:0]      quot_o
);
  localparam int CntW = $clog2(N + 1);

  logic [N-1:0]    dq_q;
  logic [M-1:0]    rem_q, dv_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [M:0]      trial;
  logic            ge;

  always_comb begin
    trial = {rem_q, dq_q[N-1]};
    ge    = trial >= {1'b0, dv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(N - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      dv_q  <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? M'(trial - {1'b0, dv_q}) : M'(trial);
      dq_q  <= {dq_q[N-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dq_q;
endmodule
`default_nettype wire

>>> dv/tb_kmeans_1d_split_refine_top.sv
// Testbench for the 1-D k-means refinement top: directed and random runs vs a behavioural predictor.
`timescale 1ns / 100ps
module tb_kmeans_1d_split_refine_top;
  localparam int NCent = 16;
  localparam int NPts  = 256;
  localparam int Settle = 20000;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] value;
    logic        last;
  } load_word_t;

  typedef struct packed {
    logic [31:0] centroid;
    logic [3:0]  slot;
    logic        final_res;
  } centroid_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, opcode = 1'b0, last = 1'b0;
  logic signed [31:0] value = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [3:0] cfg_data = '0;
  logic in_ready, out_valid, final_res, cfg_ready;
  logic signed [31:0] centroid;
  logic [3:0] slot;

  load_word_t pending_words[$];
  centroid_word_t expected_centroids[$];
  int send_idle = 0, recv_idle = 0, errors = 0;
  longint cycles = 0;
  logic in_taken = 1'b0;

  // predictor state
  int unsigned pass_count = 5;
  logic signed [31:0] cent_mem[NCent];
  logic signed [31:0] point_mem[NPts];
  int cent_total = 0, point_total = 0, active = 0;

  always #5 clk = ~clk;

  kmeans_1d_split_refine_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .value_i(value), .last_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .centroid_o(centroid), .slot_o(slot), .final_res_o(final_res),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  function automatic void refine_pass();
    longint sum[NCent];
    int cnt[NCent];
    longint mn[NCent], mx[NCent];
    int ic, widest, k;
    longint maxd, lb, ub, p, best, d, diam, third;
    ic = 0; widest = 0; maxd = 0; lb = 0; ub = 0;
    for (int j = 0; j < NCent; j++) begin
      sum[j] = 0; cnt[j] = 0; mn[j] = 0; mx[j] = 0;
    end
    if (active == 0) return;
    for (int i = 0; i < point_total; i++) begin
      p = point_mem[i];
      best = p - cent_mem[0];
      if (best < 0) best = -best;
      k = 0;
      for (int j = 1; j < active; j++) begin
        d = p - cent_mem[j];
        if (d < 0) d = -d;
        if (d < best) begin
          best = d; k = j;
        end
      end
      if (cnt[k] == 0) begin
        mn[k] = p; mx[k] = p;
      end else begin
        if (p < mn[k]) mn[k] = p;
        if (p > mx[k]) mx[k] = p;
      end
      sum[k] += p;
      cnt[k]++;
    end
    for (int j = 0; j < active; j++) begin
      if (cnt[j] != 0) begin
        cent_mem[ic] = 32'(sum[j] / longint'(cnt[j]));
        diam = mx[j] - mn[j];
        if (diam > maxd || ic == 0) begin
          if (diam > maxd) maxd = diam;
          widest = ic; lb = mn[j]; ub = mx[j];
        end
        ic++;
      end
    end
    if (ic > 0 && ic < cent_total) begin
      third = (ub - lb) / 3;
      cent_mem[widest] = 32'(lb + third);
      cent_mem[ic] = 32'(ub - third);
      ic++;
    end
    active = ic;
  endfunction

  function automatic void predict_word(load_word_t w);
    logic signed [31:0] key;
    int j;
    centroid_word_t e;
    if (!w.opcode) begin
      if (cent_total < NCent) cent_mem[cent_total++] = w.value;
      return;
    end
    if (point_total < NPts) point_mem[point_total++] = w.value;
    if (!w.last) return;
    active = cent_total;
    for (int i = 0; i < pass_count; i++) refine_pass();
    for (int i = 1; i < active; i++) begin
      key = cent_mem[i];
      j = i;
      while (j > 0 && cent_mem[j-1] > key) begin
        cent_mem[j] = cent_mem[j-1];
        j--;
      end
      cent_mem[j] = key;
    end
    for (int i = 0; i < cent_total; i++) begin
      e.centroid = cent_mem[i];
      e.slot = 4'(i);
      e.final_res = (i + 1 == cent_total);
      expected_centroids.push_back(e);
    end
    cent_total = 0;
    point_total = 0;
  endfunction

  // monitor
  always @(posedge clk) begin
    centroid_word_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_word({opcode, value, last});
    if (rst_n && out_valid && out_ready) begin
      if (expected_centroids.size() == 0) begin
        $error("unexpected word: centroid %0d slot %0d", centroid, slot);
        errors++;
      end else begin
        e = expected_centroids.pop_front();
        if (centroid !== e.centroid) begin
          $error("centroid: expected %0d, got %0d", $signed(e.centroid), centroid);
          errors++;
        end
        if (slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot);
          errors++;
        end
        if (final_res !== e.final_res) begin
          $error("final_res: expected %0d, got %0d", e.final_res, final_res);
          errors++;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    load_word_t w;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          w = pending_words.pop_front();
          opcode <= w.opcode; value <= w.value; last <= w.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [31:0] pick_value(int mode, logic [31:0] base);
    case (mode)
      0: return $urandom;
      1: return base + 32'($urandom_range(0, 2000000)) - 32'd1000000;
      default: return base + 32'($urandom_range(0, 40)) - 32'd20;
    endcase
  endfunction

  task automatic push_word(logic op, logic [31:0] v, logic l);
    load_word_t w;
    w.opcode = op; w.value = v; w.last = l;
    pending_words.push_back(w);
  endtask

  task automatic add_run(int nc, int np, output int words);
    int mode;
    logic [31:0] base;
    mode = $urandom_range(0, 2);
    base = $urandom;
    for (int i = 0; i < nc; i++)
      push_word(1'b0, pick_value(mode, base), $urandom_range(0, 7) == 0);
    for (int i = 0; i < np; i++)
      push_word(1'b1, pick_value(mode, base), i == np - 1);
    words = nc + np;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_centroids.size() != 0);
  endtask

  task automatic write_passes(logic [3:0] n);
    drain();
    repeat (Settle) @(posedge clk);
    @(negedge clk);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    pass_count = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int target);
    int count, w;
    count = 0;
    while (count < target) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        count++;
      end else begin
        add_run($urandom_range(0, 17), $urandom_range(1, 12), w);
        count += w;
      end
    end
  endtask

  initial begin
    int w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_passes(4'd1);
    send_idle = 10; recv_idle = 46;
    push_word(1'b0, 32'h8000_0000, 1'b0);
    push_word(1'b0, 32'h7fff_ffff, 1'b1);
    push_word(1'b0, 32'h0000_0000, 1'b0);
    push_word(1'b1, 32'h8000_0000, 1'b0);
    push_word(1'b1, 32'h7fff_ffff, 1'b0);
    push_word(1'b1, 32'hffff_ffff, 1'b0);
    push_word(1'b1, 32'h0000_0001, 1'b1);
    push_word(1'b1, 32'h0001_0000, 1'b1);
    push_word(1'b0, 32'h0000_0010, 1'b0);
    push_word(1'b0, 32'h0000_0010, 1'b0);
    push_word(1'b1, 32'h0000_0008, 1'b0);
    push_word(1'b1, 32'h0000_0018, 1'b1);
    for (int i = 0; i < 18; i++) push_word(1'b0, 32'(i * 1000), 1'b0);
    push_word(1'b1, 32'd5, 1'b1);
    drain();

    write_passes(4'd0);
    add_run(5, 3, w);
    write_passes(4'd15);
    random_phase(20);
    write_passes(4'd7);
    send_idle = 46; recv_idle = 10;
    random_phase(20);
    write_passes(4'd2);
    send_idle = 0; recv_idle = 0;
    add_run(3, 258, w);
    random_phase(10);

    drain();
    repeat (Settle) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
